// ----- src/assert_macros.svh -----
// Assertion macros used by the cache checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked and reset-qualified
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked and reset-qualified
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lkhc_pkg.sv -----
// Shared types and constants for the keyed handle cache
package lkhc_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int FIELD_W      = 32;
  localparam int TEXT_W       = 32;
  localparam int RSP_SLOT_W   = 4;
  localparam int CAP_W        = 5;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_HIT   = 3'd0,
    ST_MISS  = 3'd1,
    ST_STALE = 3'd2,
    ST_EMPTY = 3'd3,
    ST_CLEAR = 3'd4
  } status_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t               op;
    logic [FIELD_W-1:0] key;
    logic [TEXT_W-1:0]  text_tag;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [RSP_SLOT_W-1:0] slot;
    logic                 evicted_valid;
    logic [FIELD_W-1:0]   evicted_key;
  } rsp_t;

  typedef struct packed {
    logic shift;
    logic vld_we;
    logic vld_d;
  } cell_ctrl_t;

endpackage

// ----- src/lru_keyed_handle_cache_top.sv -----
// Keyed handle cache top: LRU stack of statement handles in a row of cells
//
// Command channel: a transaction (req) is taken at a rising edge with start high
// and busy low. req.op selects get-or-insert or clear of the whole cache.
// Each transaction gives exactly one result on rsp, marked by done for one
// cycle; the receiver cannot stall it.
// Timing: busy rises after the accepting edge and falls when done shows, so a
// new transaction can be taken in the cycle in which done is high. A transaction
// runs through the lookup / plan / commit sequence over the cell row: all cells
// compare in parallel, then eviction and the lowest free slot are worked out,
// then every cell loads from its left neighbor or holds in one step.
// Configuration: APB write of capacity at byte address 0, while idle.
// Reset: all cells invalid, count zero, capacity 16, no result pending.
module lru_keyed_handle_cache_top #(
  parameter int DEPTH    = lkhc_pkg::DEPTH_DEF,
  parameter int KEY_BITS = lkhc_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lkhc_pkg::req_t                req,
  output logic                          done,
  output lkhc_pkg::rsp_t                rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkhc_pkg::ADDR_W-1:0]   paddr,
  input  logic [lkhc_pkg::DATA_W-1:0]   pwdata,
  output logic [lkhc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lkhc_pkg::*;

  localparam int KEY_W  = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int IDX_W  = SLOT_W;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {IDLE, LOOK, PLAN, COMMIT} state_t;

  state_t state;

  // config
  logic [CAP_W-1:0] capacity;
  logic             cfg_wr;
  logic [CMP_W-1:0] cap_wide;
  logic [CNT_W-1:0] cap_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr && (reg_idx_t'(paddr[2]) == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (reg_idx_t'(paddr[2]) == REG_CAPACITY) ? DATA_W'(capacity) : '0;

  assign cap_wide = CMP_W'(capacity);

  always_comb begin
    if (cap_wide == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_wide > CMP_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = cap_wide[CNT_W-1:0];
    end
  end

  // request
  op_t               req_op;
  logic [KEY_W-1:0]  req_key;
  logic [TEXT_W-1:0] req_text;
  logic              accept;

  assign busy   = (state != IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= req.op;
      req_key  <= req.key[KEY_W-1:0];
      req_text <= req.text_tag;
    end
  end

  // cell row
  logic [DEPTH-1:0]  c_valid;
  logic [DEPTH-1:0]  c_match;
  logic [DEPTH-1:0]  c_teq;
  logic [KEY_W-1:0]  c_key  [DEPTH];
  logic [TEXT_W-1:0] c_text [DEPTH];
  logic [SLOT_W-1:0] c_slot [DEPTH];
  cell_ctrl_t        c_ctrl [DEPTH];
  logic [SLOT_W-1:0] head_slot;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      lkhc_cell #(.KEY_W(KEY_W), .SLOT_W(SLOT_W)) u_cell (
        .clk(clk), .rst(rst), .ctrl(c_ctrl[g]),
        .left_key(req_key), .left_text(req_text), .left_slot(head_slot),
        .cmp_key(req_key), .cmp_text(req_text),
        .valid(c_valid[g]), .key(c_key[g]), .text(c_text[g]), .slot(c_slot[g]),
        .match(c_match[g]), .text_eq(c_teq[g])
      );
    end else begin : g_body
      lkhc_cell #(.KEY_W(KEY_W), .SLOT_W(SLOT_W)) u_cell (
        .clk(clk), .rst(rst), .ctrl(c_ctrl[g]),
        .left_key(c_key[g-1]), .left_text(c_text[g-1]), .left_slot(c_slot[g-1]),
        .cmp_key(req_key), .cmp_text(req_text),
        .valid(c_valid[g]), .key(c_key[g]), .text(c_text[g]), .slot(c_slot[g]),
        .match(c_match[g]), .text_eq(c_teq[g])
      );
    end
  end

  // lookup
  logic              look_found;
  logic              look_teq;
  logic [IDX_W-1:0]  look_idx;
  logic [SLOT_W-1:0] look_slot;
  logic              found;
  logic              hit_teq;
  logic [IDX_W-1:0]  hit_idx;
  logic [SLOT_W-1:0] hit_slot;

  always_comb begin
    look_found = |c_match;
    look_teq   = |(c_match & c_teq);
    look_idx   = '0;
    look_slot  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (c_match[i]) begin
        look_idx  = look_idx | IDX_W'(i);
        look_slot = look_slot | c_slot[i];
      end
    end
  end

  // plan
  logic              is_hit;
  logic              is_stale;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cnt_d;
  logic [CNT_W-1:0]  ev_pos;
  logic [IDX_W-1:0]  ev_idx;
  logic              plan_evict;
  logic [DEPTH-1:0]  keep;
  logic [KEY_W-1:0]  plan_ev_key;
  logic [SLOT_W-1:0] alloc_slot;
  logic              evict;
  logic [KEY_W-1:0]  ev_key;
  logic [SLOT_W-1:0] new_slot;
  logic [CNT_W-1:0]  cnt_new;
  logic [CNT_W-1:0]  plan_cnt_new;

  assign is_hit   = found && hit_teq;
  assign is_stale = found && !hit_teq;
  assign cnt_d    = count - CNT_W'(is_stale);
  assign plan_evict = !is_hit && (cnt_d != '0) && (cnt_d >= cap_eff);
  assign ev_pos   = (is_stale && (CNT_W'(hit_idx) < cnt_d)) ? cnt_d : (cnt_d - CNT_W'(1));
  assign ev_idx   = ev_pos[IDX_W-1:0];
  assign plan_cnt_new = is_hit ? count : (cnt_d - CNT_W'(plan_evict) + CNT_W'(1));

  always_comb begin
    plan_ev_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = c_valid[i] && !(is_stale && (hit_idx == IDX_W'(i)))
                && !(plan_evict && (ev_idx == IDX_W'(i)));
      if (plan_evict && (ev_idx == IDX_W'(i))) begin
        plan_ev_key = plan_ev_key | c_key[i];
      end
    end
  end

  lkhc_slot_alloc #(.DEPTH(DEPTH), .SLOT_W(SLOT_W)) u_slot_alloc (
    .keep(keep),
    .slots(c_slot),
    .free_slot(alloc_slot)
  );

  // commit
  logic             normal;
  logic             is_clear;
  logic [IDX_W-1:0] shift_bound;
  status_t          status_sel;

  assign is_clear    = (req_op == OP_CLEAR);
  assign normal      = !is_clear && (req_key != '0);
  assign shift_bound = found ? hit_idx : IDX_W'(DEPTH - 1);
  assign head_slot   = is_hit ? hit_slot : new_slot;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      c_ctrl[i].shift  = (state == COMMIT) && normal && (IDX_W'(i) <= shift_bound);
      c_ctrl[i].vld_we = (state == COMMIT) && (is_clear || normal);
      c_ctrl[i].vld_d  = !is_clear && (CNT_W'(i) < cnt_new);
    end
  end

  always_comb begin
    if (is_clear) begin
      status_sel = ST_CLEAR;
    end else if (!normal) begin
      status_sel = ST_EMPTY;
    end else if (is_hit) begin
      status_sel = ST_HIT;
    end else if (is_stale) begin
      status_sel = ST_STALE;
    end else begin
      status_sel = ST_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            state <= LOOK;
          end
        end
        LOOK: begin
          found    <= look_found;
          hit_teq  <= look_teq;
          hit_idx  <= look_idx;
          hit_slot <= look_slot;
          state    <= PLAN;
        end
        PLAN: begin
          evict    <= plan_evict;
          ev_key   <= plan_ev_key;
          new_slot <= alloc_slot;
          cnt_new  <= plan_cnt_new;
          state    <= COMMIT;
        end
        COMMIT: begin
          done       <= 1'b1;
          rsp.status <= status_sel;
          if (normal) begin
            count             <= cnt_new;
            rsp.slot          <= RSP_SLOT_W'(head_slot);
            rsp.evicted_valid <= evict;
            rsp.evicted_key   <= evict ? FIELD_W'(ev_key) : '0;
          end else begin
            if (is_clear) begin
              count <= '0;
            end
            rsp.slot          <= '0;
            rsp.evicted_valid <= 1'b0;
            rsp.evicted_key   <= '0;
          end
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/lkhc_cell.sv -----
// One LRU stack cell: holds an entry, compares it, loads from its left neighbor
module lkhc_cell #(
  parameter int KEY_W  = 32,
  parameter int SLOT_W = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lkhc_pkg::cell_ctrl_t      ctrl,
  input  logic [KEY_W-1:0]          left_key,
  input  logic [lkhc_pkg::TEXT_W-1:0] left_text,
  input  logic [SLOT_W-1:0]         left_slot,
  input  logic [KEY_W-1:0]          cmp_key,
  input  logic [lkhc_pkg::TEXT_W-1:0] cmp_text,
  output logic                      valid,
  output logic [KEY_W-1:0]          key,
  output logic [lkhc_pkg::TEXT_W-1:0] text,
  output logic [SLOT_W-1:0]         slot,
  output logic                      match,
  output logic                      text_eq
);
  import lkhc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.vld_we) begin
      valid <= ctrl.vld_d;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key  <= left_key;
      text <= left_text;
      slot <= left_slot;
    end
  end

  assign match   = valid && (key == cmp_key);
  assign text_eq = (text == cmp_text);

endmodule

// ----- src/lkhc_slot_alloc.sv -----
// Lowest free handle slot among the entries that survive the update
module lkhc_slot_alloc #(
  parameter int DEPTH  = 16,
  parameter int SLOT_W = 4
) (
  input  logic [DEPTH-1:0]  keep,
  input  logic [SLOT_W-1:0] slots [DEPTH],
  output logic [SLOT_W-1:0] free_slot
);
  import lkhc_pkg::*;

  logic [DEPTH-1:0] used;
  logic [DEPTH-1:0] free;
  logic [DEPTH-1:0] lowest;

  always_comb begin
    used = '0;
    for (int s = 0; s < DEPTH; s++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (keep[i] && (slots[i] == SLOT_W'(s))) begin
          used[s] = 1'b1;
        end
      end
    end
  end

  assign free   = ~used;
  assign lowest = free & (~free + DEPTH'(1));

  always_comb begin
    free_slot = '0;
    for (int s = 0; s < DEPTH; s++) begin
      if (lowest[s]) begin
        free_slot = free_slot | SLOT_W'(s);
      end
    end
  end

endmodule

// ----- src/lkhc_checker.sv -----
// Port-level checks for the keyed handle cache, bound to the top level
`include "assert_macros.svh"

module lkhc_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input lkhc_pkg::rsp_t rsp
);
  import lkhc_pkg::*;

  logic accept;
  logic status_ok;
  logic ev_none;

  assign accept    = start && !busy;
  assign status_ok = (rsp.status == ST_HIT) || (rsp.status == ST_MISS) ||
                     (rsp.status == ST_STALE) || (rsp.status == ST_EMPTY) ||
                     (rsp.status == ST_CLEAR);
  assign ev_none   = done && !rsp.evicted_valid;

  `ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "busy not raised after accept")
  `ASSERT_IMPL(a_latency, clk, rst, accept, ##4 done, "result not four cycles after accept")
  `ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "busy still high with result strobe")
  `ASSERT_IMPL(a_status, clk, rst, done, status_ok, "status code out of range")
  `ASSERT_IMPL(a_ev_key, clk, rst, ev_none, rsp.evicted_key == '0, "evicted key without eviction")

endmodule

bind lru_keyed_handle_cache_top lkhc_checker u_lkhc_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .rsp(rsp)
);
